// ----- rtl/fpa_pkg.sv -----
// Package for the fixed-point ALU: opcodes, beat structs, sizing constants.
// No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;
	localparam int unsigned FracBitsDefault = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned KindW = 4;
	localparam int unsigned DivW = 64;

	typedef enum logic [KindW-1:0] {
		K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3,
		K_MIN = 4'd4, K_MAX = 4'd5, K_EQ = 4'd6, K_NE = 4'd7,
		K_GT = 4'd8, K_GE = 4'd9, K_LT = 4'd10, K_LE = 4'd11,
		K_INC = 4'd12, K_DEC = 4'd13, K_TOINT = 4'd14, K_NONE = 4'd15
	} kind_t;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic signed [WordW-1:0] operand_a;
		logic signed [WordW-1:0] operand_b;
	} in_beat_t;

	typedef struct packed {
		logic signed [WordW-1:0] result_raw;
		logic compare_true;
		logic divide_by_zero;
	} out_beat_t;

	// carried down the divider chain
	typedef struct packed {
		logic              vld;
		logic              is_div;
		logic              neg;
		logic              dz;
		logic [WordW-1:0]  fast;
		logic              cmp;
		logic [DivW-1:0]   num;
		logic [DivW-1:0]   rem;
		logic [WordW-1:0]  den;
	} cell_t;
endpackage

// ----- rtl/fpa_div_cell.sv -----
// One radix-2 restoring division step, registered; holds one beat in flight.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fpa_pkg::cell_t d,
	output fpa_pkg::cell_t q
);
	import fpa_pkg::*;
	logic [DivW:0] trial;
	logic [DivW-1:0] rsh;
	cell_t nx;

	always_comb begin
		rsh = {d.rem[DivW-2:0], d.num[DivW-1]};
		trial = {1'b0, rsh} - {{(DivW-WordW+1){1'b0}}, d.den};
		nx = d;
		nx.num = {d.num[DivW-2:0], ~trial[DivW]};
		nx.rem = trial[DivW] ? rsh : trial[DivW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

// ----- rtl/fpa_front.sv -----
// Entry stage: add, subtract, compare and other simple ops, multiply, divider operand set-up.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  fpa_pkg::in_beat_t d,
	output fpa_pkg::cell_t  q
);
	import fpa_pkg::*;
	logic signed [WordW-1:0] a, b;
	logic signed [2*WordW-1:0] prod;
	logic [WordW-1:0] ma, mb, res;
	logic lt, eq, cmp;
	cell_t nx;

	assign a = d.operand_a;
	assign b = d.operand_b;
	assign prod = a * b;
	assign lt = a < b;
	assign eq = a == b;
	assign ma = a[WordW-1] ? WordW'(-a) : a;
	assign mb = b[WordW-1] ? WordW'(-b) : b;

	always_comb begin
		res = '0;
		cmp = 1'b0;
		case (d.kind)
			K_ADD:   res = a + b;
			K_SUB:   res = a - b;
			K_MUL:   res = prod[FRAC_BITS +: WordW];
			K_MIN:   res = lt ? a : b;
			K_MAX:   res = (!lt && !eq) ? a : b;
			K_EQ:    cmp = eq;
			K_NE:    cmp = !eq;
			K_GT:    cmp = !lt && !eq;
			K_GE:    cmp = !lt;
			K_LT:    cmp = lt;
			K_LE:    cmp = lt || eq;
			K_INC:   res = a + 1;
			K_DEC:   res = a - 1;
			K_TOINT: res = a >>> FRAC_BITS;
			default: res = '0;
		endcase
		nx.vld = vld;
		nx.is_div = d.kind == K_DIV;
		nx.neg = a[WordW-1] ^ b[WordW-1];
		nx.dz = (d.kind == K_DIV) && (b == '0);
		nx.fast = res;
		nx.cmp = cmp;
		nx.num = {{(DivW-WordW){1'b0}}, ma} << FRAC_BITS;
		nx.rem = '0;
		nx.den = mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

// ----- rtl/fixed_point_alu_core.sv -----
// Pipeline: 1 entry stage, 64 division cells and 1 output register; every
// opcode passes through all of them.
// Throughput: one beat per cycle; the whole chain advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits; the chain starts empty.
// Depends on fpa_pkg, fpa_front, fpa_div_cell.
`timescale 1ns / 1ps
module fixed_point_alu_core #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fpa_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fpa_pkg::out_beat_t out_data
);
	import fpa_pkg::*;
	cell_t chain [DivW+1];
	logic en;
	logic [WordW-1:0] q32;
	cell_t t;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(in_valid),
		.d(in_data), .q(chain[0])
	);

	for (genvar i = 0; i < DivW; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(chain[i]), .q(chain[i+1])
		);
	end

	assign t = chain[DivW];
	assign q32 = t.num[WordW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= t.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.compare_true <= t.cmp;
			out_data.divide_by_zero <= t.dz;
			if (t.dz)
				out_data.result_raw <= '0;
			else if (t.is_div)
				out_data.result_raw <= t.neg ? WordW'(-q32) : q32;
			else
				out_data.result_raw <= t.fast;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |-> out_data.result_raw == '0)
		else $error("divide by zero with non-zero result");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.divide_by_zero && out_data.compare_true))
		else $error("compare and divide flags together");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
endmodule

// ----- test/testbench.sv -----
// Self-checking bench for fixed_point_alu_core: directed corner beats, then random traffic.
// A queue-based scoreboard class predicts each result. Depends on fpa_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
	import fpa_pkg::*;

	localparam int unsigned FRAC = FracBitsDefault;
	localparam int NumRandom = 1530;
	localparam int CycleLimit = 200000;

	class alu_scoreboard;
		out_beat_t pending[$];
		int errors;

		function out_beat_t compute(in_beat_t x);
			out_beat_t r;
			logic signed [63:0] a, b, prod;
			logic [63:0] ma, mb, q;
			r = '0;
			a = 64'(x.operand_a);
			b = 64'(x.operand_b);
			case (kind_t'(x.kind))
				K_ADD: r.result_raw = x.operand_a + x.operand_b;
				K_SUB: r.result_raw = x.operand_a - x.operand_b;
				K_MUL: begin
					prod = a * b;
					r.result_raw = 32'(prod >>> FRAC);
				end
				K_DIV: begin
					if (b == 0) begin
						r.divide_by_zero = 1'b1;
					end else begin
						ma = a < 0 ? -a : a;
						mb = b < 0 ? -b : b;
						q = (ma << FRAC) / mb;
						r.result_raw = 32'(((a < 0) != (b < 0)) ? -q : q);
					end
				end
				K_MIN: r.result_raw = (a < b) ? x.operand_a : x.operand_b;
				K_MAX: r.result_raw = (a > b) ? x.operand_a : x.operand_b;
				K_EQ: r.compare_true = a == b;
				K_NE: r.compare_true = a != b;
				K_GT: r.compare_true = a > b;
				K_GE: r.compare_true = a >= b;
				K_LT: r.compare_true = a < b;
				K_LE: r.compare_true = a <= b;
				K_INC: r.result_raw = x.operand_a + 32'sd1;
				K_DEC: r.result_raw = x.operand_a - 32'sd1;
				K_TOINT: r.result_raw = x.operand_a >>> FRAC;
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_input(in_beat_t x);
			pending.push_back(compute(x));
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp res=%h cmp=%b dz=%b got res=%h cmp=%b dz=%b",
						exp_r.result_raw, exp_r.compare_true, exp_r.divide_by_zero,
						got.result_raw, got.compare_true, got.divide_by_zero);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	alu_scoreboard board = new();
	bit calm = 1'b0;
	int cycles = 0;

	always #5 clk = ~clk;

	fixed_point_alu_core u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
	end

	// receiver stall bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(kind_t k, logic [31:0] a, logic [31:0] b);
		in_beat_t x;
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		x.kind = k;
		x.operand_a = a;
		x.operand_b = b;
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (in_stall);
		board.note_input(x);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'(int'($urandom_range(0, 2048)) - 1024);
			1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			3: return 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] ra, rb;
		kind_t k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 16; i++)
			send_beat(kind_t'(i), 32'h7FFFFFFF, 32'h80000000);
		send_beat(K_DIV, 32'h00000100, 32'h00000000);
		send_beat(K_DIV, 32'h80000000, 32'hFFFFFFFF);
		send_beat(K_MIN, 32'h00000500, 32'h00000500);
		send_beat(K_MAX, 32'hFFFFFF00, 32'hFFFFFF00);
		send_beat(K_MUL, 32'h80000000, 32'h80000000);
		send_beat(K_INC, 32'h7FFFFFFF, 32'h0);
		send_beat(K_DEC, 32'h80000000, 32'h0);
		send_beat(K_TOINT, 32'hFFFFFF7F, 32'h0);
		send_beat(K_EQ, 32'hFFFFFFFF, 32'hFFFFFFFF);
		for (int i = 0; i < NumRandom; i++) begin
			if (i > NumRandom - 200)
				calm = 1'b1;
			k = kind_t'($urandom_range(0, 15));
			ra = rand_operand();
			rb = ($urandom_range(0, 7) == 0) ? ra : rand_operand();
			send_beat(k, ra, rb);
		end
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
